// ===== rtl/tln_pkg.sv =====
// Shared character codes, mode codes and types for the text line numberer.
package tln_pkg;

   typedef logic [7:0] char_type;
   typedef logic [3:0] bcd_digit_type;
   typedef logic [1:0] mode_code_type;

   localparam char_type CH_NEWLINE = 8'h0A;
   localparam char_type CH_TAB     = 8'h09;
   localparam char_type CH_SPACE   = 8'h20;
   localparam char_type CH_ZERO    = 8'h30;
   localparam char_type CH_NINE    = 8'h39;

   localparam bcd_digit_type BCD_ZERO = 4'd0;
   localparam bcd_digit_type BCD_ONE  = 4'd1;
   localparam bcd_digit_type BCD_NINE = 4'd9;

   localparam mode_code_type MODE_ALL      = 2'd0;
   localparam mode_code_type MODE_NONBLANK = 2'd1;
   localparam mode_code_type MODE_NONE     = 2'd2;

endpackage

// ===== rtl/tln_counter.sv =====
// Saturating BCD line counter with right-justified digit glyphs.
module tln_counter
   import tln_pkg::*;
#(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   output char_type [NUMBER_DIGITS-1:0]        glyph
);

   bcd_digit_type [NUMBER_DIGITS-1:0] digits_ff;
   bcd_digit_type [NUMBER_DIGITS-1:0] digits_in;

   always_comb begin
      logic full;
      logic carry;
      digits_in = digits_ff;
      full      = 1'b1;
      carry     = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (digits_ff[i] != BCD_NINE) begin
            full = 1'b0;
         end
      end
      if (advance && !full) begin
         for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
               if (digits_ff[i] == BCD_NINE) begin
                  digits_in[i] = BCD_ZERO;
               end else begin
                  digits_in[i] = digits_ff[i] + BCD_ONE;
                  carry        = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff    <= '0;
         digits_ff[0] <= BCD_ONE;
      end else begin
         digits_ff <= digits_in;
      end
   end

   // print position 0 is the most significant digit
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int p = 0; p < NUMBER_DIGITS; p++) begin
         if (digits_ff[NUMBER_DIGITS-1-p] != BCD_ZERO || p == NUMBER_DIGITS - 1) begin
            seen = 1'b1;
         end
         glyph[p] = seen ? char_type'(CH_ZERO + {4'd0, digits_ff[NUMBER_DIGITS-1-p]})
                         : CH_SPACE;
      end
   end

endmodule

// ===== rtl/tln_emitter.sv =====
// Input item register, prefix sequencer and result register.
module tln_emitter
   import tln_pkg::*;
#(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  char_type                     req_tdata,
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output char_type                     rsp_tdata,
   output logic                         rsp_tlast,
   input  mode_code_type                mode,
   input  char_type [NUMBER_DIGITS-1:0] glyph,
   output logic                         advance
);

   localparam int PosW = $clog2(NUMBER_DIGITS + 2);
   localparam logic [PosW-1:0] PosTab  = PosW'(NUMBER_DIGITS);
   localparam logic [PosW-1:0] PosByte = PosW'(NUMBER_DIGITS + 1);

   logic            item_valid_ff, item_valid_in;
   char_type        item_byte_ff, item_byte_in;
   logic            item_start_ff, item_start_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            at_line_start_ff, at_line_start_in;
   logic            rsp_valid_ff, rsp_valid_in;
   char_type        rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic     line_start;
   logic     numbered;
   logic     step;
   logic     emit_last;
   char_type emit_byte;
   char_type digit_byte;
   logic     req_xfer;

   assign line_start = at_line_start_ff | item_start_ff;
   assign numbered   = (mode == MODE_ALL) ||
                       (mode == MODE_NONBLANK && item_byte_ff != CH_NEWLINE);
   assign step       = item_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      digit_byte = CH_SPACE;
      for (int p = 0; p < NUMBER_DIGITS; p++) begin
         if (pos_ff == PosW'(p)) begin
            digit_byte = glyph[p];
         end
      end
   end

   always_comb begin
      emit_byte = item_byte_ff;
      emit_last = 1'b1;
      if (line_start) begin
         if (pos_ff == PosByte) begin
            emit_byte = item_byte_ff;
            emit_last = 1'b1;
         end else if (pos_ff == PosTab) begin
            emit_byte = CH_TAB;
            emit_last = 1'b0;
         end else begin
            emit_byte = numbered ? digit_byte : CH_SPACE;
            emit_last = 1'b0;
         end
      end
   end

   assign advance    = step && line_start && numbered && pos_ff == PosTab;
   assign req_tready = !item_valid_ff || (step && emit_last);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      item_valid_in    = item_valid_ff;
      item_byte_in     = item_byte_ff;
      item_start_in    = item_start_ff;
      pos_in           = pos_ff;
      at_line_start_in = at_line_start_ff;
      if (step) begin
         if (emit_last) begin
            pos_in           = '0;
            item_valid_in    = 1'b0;
            at_line_start_in = (item_byte_ff == CH_NEWLINE);
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (req_xfer) begin
         item_valid_in = 1'b1;
         item_byte_in  = req_tdata;
         item_start_in = req_tuser;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff    <= 1'b0;
         pos_ff           <= '0;
         at_line_start_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         item_valid_ff    <= item_valid_in;
         pos_ff           <= pos_in;
         at_line_start_ff <= at_line_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff  <= item_byte_in;
      item_start_ff <= item_start_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/text_line_numberer_top.sv =====
// Top level of the text line numberer: mode register, counter and emitter.
//
//   channel  | direction | transfer content
//   ---------+-----------+-------------------------------------------------
//   req_     | in        | tdata: text_byte[7:0]; tuser: file_start
//   rsp_     | out       | tdata: out_byte[7:0];  tlast: last
//   csr_     | in        | wdata: number_mode[1:0], written when csr_we
//
// A byte inside a line is emitted on its own; a byte that starts a line is
// preceded by NUMBER_DIGITS number or space characters and a tab, one per
// position of the emitter's position sequencer driving one result register.
// A new request is taken in the same cycle the previous one emits its byte.
// Reset is synchronous; it sets mode 1, line number one and line start.
// A stalled rsp_tready holds the result register and backs up into req_tready.
module text_line_numberer_top
   import tln_pkg::*;
#(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] text_byte
   input  logic          req_tuser,   // [0] file_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // [7:0] out_byte
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [1:0]    csr_wdata
);

   mode_code_type                mode_ff, mode_in;
   char_type [NUMBER_DIGITS-1:0] glyph;
   logic                         advance;

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONBLANK;
      end else begin
         mode_ff <= mode_in;
      end
   end

   tln_counter #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_counter (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .glyph   (glyph)
   );

   tln_emitter #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mode       (mode_ff),
      .glyph      (glyph),
      .advance    (advance)
   );

endmodule

// ===== rtl/tln_checker.sv =====
// Port-level checker for the text line numberer and its bind.
module tln_checker
   import tln_pkg::*;
#(
   parameter int NUMBER_DIGITS = 6
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   localparam int RunW = $clog2(NUMBER_DIGITS + 2);
   localparam logic [RunW-1:0] RunFull = RunW'(NUMBER_DIGITS + 1);

   logic            rsp_xfer;
   logic [RunW-1:0] run_ff, run_in;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      run_in = run_ff;
      if (rsp_xfer) begin
         run_in = rsp_tlast ? '0 : ((run_ff == RunFull) ? run_ff : run_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_prefix_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tdata == CH_SPACE || rsp_tdata == CH_TAB ||
         (rsp_tdata >= CH_ZERO && rsp_tdata <= CH_NINE))
      else $error("prefix byte is not a space, tab or digit");

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_tlast |-> run_ff < RunFull)
      else $error("prefix too long");

   a_prefix_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_tlast && run_ff != '0 |-> run_ff == RunFull)
      else $error("prefix cut short");

endmodule

bind text_line_numberer_top tln_checker #(
   .NUMBER_DIGITS(NUMBER_DIGITS)
) u_tln_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
